// ===== rtl/trfd_pkg.sv =====
// ----------------------------------------------------------------------------
// trfd_pkg
// Types, codes and constants shared by the touch report frame decoder.
// ----------------------------------------------------------------------------
package trfd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned COORD_W    = 12;
    localparam int unsigned PROD_W     = 2 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_X_RES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_Y_RES  = 3'd5;

    localparam logic [1:0] KIND_FINGER = 2'd0;
    localparam logic [1:0] KIND_SYNC   = 2'd1;
    localparam logic [1:0] KIND_PENUP  = 2'd2;

    localparam logic [1:0] EMPTY_MASK  = 2'b11;
    localparam logic [3:0] MIN_STRIDE  = 4'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_X,
        S_DIV_X,
        S_MUL_Y,
        S_DIV_Y,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic decode;
        logic mul;
        logic mul_y;
        logic save_x;
        logic div_step;
        logic emit_finger;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic in_range;
        logic end_emit;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/trfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// trfd_ctrl
// Sequencer: decode, multiply/divide for x and y, range check, record finish.
// ----------------------------------------------------------------------------
module trfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  trfd_pkg::t_status i_status,
    output trfd_pkg::t_cmd    o_cmd
);
    import trfd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_status.need_div ? S_MUL_X : S_FINISH;
            end
            S_MUL_X: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV_X;
            end
            S_DIV_X: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MUL_Y;
                end
            end
            S_MUL_Y: begin
                o_cmd.save_x = 1'b1;
                o_cmd.mul    = 1'b1;
                o_cmd.mul_y  = 1'b1;
                n_state      = S_DIV_Y;
            end
            S_DIV_Y: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.in_range) begin
                    n_state = S_FINISH;
                end else if (i_status.out_free) begin
                    o_cmd.emit_finger = 1'b1;
                    n_state           = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_status.end_emit || i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_DECODE)
        else $error("accepted word not followed by decode");

    a_check_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> $past(r_state) == S_DIV_Y || $past(r_state) == S_CHECK)
        else $error("range check entered without y divide");

endmodule

// ===== rtl/trfd_datapath.sv =====
// ----------------------------------------------------------------------------
// trfd_datapath
// Config registers, record counters, shared multiplier, radix-2 divider and
// output register.
// ----------------------------------------------------------------------------
module trfd_datapath #(
    parameter int unsigned MAX_RECORDS = 10,
    parameter int unsigned FRAME_BYTES = 60
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  trfd_pkg::t_cmd                     i_cmd,
    output trfd_pkg::t_status                  o_status,
    input  trfd_pkg::t_in_word                 i_in_word,
    input  logic                               i_cfg_write,
    input  logic [trfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [trfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    output trfd_pkg::t_out_word                o_out_word,
    input  logic                               i_out_stall
);
    import trfd_pkg::*;

    localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

    logic [3:0]         r_fc;
    logic [3:0]         r_rb;
    logic [COORD_W-1:0] r_sw;
    logic [COORD_W-1:0] r_sh;
    logic [COORD_W-1:0] r_sxr;
    logic [COORD_W-1:0] r_syr;

    logic [3:0]         r_bir;
    logic [3:0]         r_ri;
    logic               r_rvalid;
    logic               r_any;
    logic               r_pen_up;
    logic [7:0]         r_byte;
    logic [7:0]         r_xh;
    logic [7:0]         r_yh;

    logic [PROD_W-1:0]    r_q;
    logic [COORD_W-1:0]   r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_sx;
    logic                 r_div_y;

    logic      r_out_valid;
    t_out_word r_out;

    logic [3:0]         w_stride;
    logic [3:0]         w_nfing;
    logic [4:0]         w_ri1;
    logic [4:0]         w_ri2;
    logic [8:0]         w_span;
    logic               w_rec_end;
    logic               w_frame_end;
    logic [COORD_W-1:0] w_rx;
    logic [COORD_W-1:0] w_ry;
    logic [COORD_W-1:0] w_mul_a;
    logic [COORD_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [COORD_W-1:0] w_div;
    logic [COORD_W:0]   w_shift;
    logic [COORD_W:0]   w_diff;
    logic               w_ge;
    logic               w_out_free;
    logic               w_load_out;

    // frame geometry
    assign w_stride  = (r_rb < MIN_STRIDE) ? MIN_STRIDE : r_rb;
    assign w_nfing   = (r_fc == 4'd0) ? 4'd1 : r_fc;
    assign w_ri1     = {1'b0, r_ri} + 5'd1;
    assign w_ri2     = w_ri1 + 5'd1;
    assign w_span    = {4'b0, w_ri2} * {5'b0, w_stride};
    assign w_rec_end = ({1'b0, r_bir} + 5'd1) >= {1'b0, w_stride};
    assign w_frame_end = w_rec_end && ((w_ri1 >= {1'b0, w_nfing})
                                    || (w_ri1 >= 5'(MAX_RECORDS))
                                    || (9'(FRAME_BYTES) < w_span));

    // scale and divide
    assign w_rx    = {r_xh, r_byte[7:4]};
    assign w_ry    = {r_yh, r_byte[3:0]};
    assign w_mul_a = i_cmd.mul_y ? w_ry : w_rx;
    assign w_mul_b = i_cmd.mul_y ? r_sxr : r_syr;
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_div   = r_div_y ? ((r_sh == '0) ? COORD_W'(1) : r_sh)
                             : ((r_sw == '0) ? COORD_W'(1) : r_sw);
    assign w_shift = {r_rem, r_q[PROD_W-1]};
    assign w_ge    = w_shift >= {1'b0, w_div};
    assign w_diff  = w_shift - {1'b0, w_div};

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = i_cmd.emit_finger
                     || (i_cmd.finish && w_frame_end && (r_any || !r_pen_up));

    assign o_status.need_div = (r_bir == 4'd3) && r_rvalid;
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.in_range = (r_sx <= PROD_W'(r_syr)) && (r_q <= PROD_W'(r_sxr));
    assign o_status.end_emit = w_frame_end && (r_any || !r_pen_up);
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc  <= 4'd5;
            r_rb  <= 4'd6;
            r_sw  <= COORD_W'(800);
            r_sh  <= COORD_W'(480);
            r_sxr <= COORD_W'(800);
            r_syr <= COORD_W'(480);
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_FINGER_COUNT:  r_fc  <= i_cfg_data[3:0];
                CFG_RECORD_BYTES:  r_rb  <= i_cfg_data[3:0];
                CFG_SENSOR_WIDTH:  r_sw  <= i_cfg_data;
                CFG_SENSOR_HEIGHT: r_sh  <= i_cfg_data;
                CFG_SCREEN_X_RES:  r_sxr <= i_cfg_data;
                CFG_SCREEN_Y_RES:  r_syr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bir    <= '0;
            r_ri     <= '0;
            r_rvalid <= 1'b0;
            r_any    <= 1'b0;
            r_pen_up <= 1'b0;
            r_xh     <= '0;
            r_yh     <= '0;
        end else begin
            if (i_cmd.accept && i_in_word.frame_start) begin
                r_bir    <= '0;
                r_ri     <= '0;
                r_rvalid <= 1'b0;
                r_any    <= 1'b0;
            end
            if (i_cmd.decode) begin
                case (r_bir)
                    4'd0: begin
                        r_rvalid <= (r_byte[1:0] != EMPTY_MASK);
                        if (r_byte[1:0] != EMPTY_MASK) begin
                            r_any <= 1'b1;
                        end
                    end
                    4'd1: r_xh <= r_byte;
                    4'd2: r_yh <= r_byte;
                    default: ;
                endcase
            end
            if (i_cmd.emit_finger) begin
                r_pen_up <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (w_frame_end) begin
                    if (!r_any && !r_pen_up) begin
                        r_pen_up <= 1'b1;
                    end
                    r_bir    <= '0;
                    r_ri     <= '0;
                    r_rvalid <= 1'b0;
                    r_any    <= 1'b0;
                end else if (w_rec_end) begin
                    r_bir <= '0;
                    r_ri  <= r_ri + 4'd1;
                end else begin
                    r_bir <= r_bir + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_in_word.data_byte;
        end
        if (i_cmd.save_x) begin
            r_sx <= r_q;
        end
        if (i_cmd.mul) begin
            r_q     <= w_prod;
            r_rem   <= '0;
            r_cnt   <= DIV_CNT_W'(PROD_W - 1);
            r_div_y <= i_cmd.mul_y;
        end else if (i_cmd.div_step) begin
            r_q   <= {r_q[PROD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[COORD_W-1:0] : w_shift[COORD_W-1:0];
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_finger) begin
            r_out.event_kind <= KIND_FINGER;
            r_out.pos_x      <= r_sxr - r_q[COORD_W-1:0];
            r_out.pos_y      <= r_sx[COORD_W-1:0];
            r_out.last       <= !w_frame_end;
        end else if (w_load_out) begin
            r_out.event_kind <= r_any ? KIND_SYNC : KIND_PENUP;
            r_out.pos_x      <= '0;
            r_out.pos_y      <= '0;
            r_out.last       <= 1'b1;
        end
    end

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_rem < w_div)
        else $error("divider remainder not below divisor");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> w_out_free)
        else $error("output word overwritten while stalled");

    a_finger_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_finger |-> r_sx <= PROD_W'(r_syr) && r_q <= PROD_W'(r_sxr))
        else $error("finger emitted out of range");

endmodule

// ===== rtl/touch_report_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// touch_report_frame_decoder_top
// Decodes a multitouch report byte stream into finger, sync and pen-up words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  in      | input     | i_in_valid / o_in_stall | t_in_word (data_byte, frame_start)
//  out     | output    | o_out_valid / i_out_stall | t_out_word (kind, x, y, last)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Each byte passes the idle, decode and finish states; byte 3 of a live record
//  also runs two 24-step serial divides through one divider unit.
//  One byte in flight at a time; the output register holds one word.
//  Synchronous active-low reset; config returns to its defaults.
//  A stalled output holds the sequencer only when it has a word to emit.
// ----------------------------------------------------------------------------
module touch_report_frame_decoder_top #(
    parameter int unsigned MAX_RECORDS = 10,
    parameter int unsigned FRAME_BYTES = 60
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  trfd_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output trfd_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [trfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [trfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import trfd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_in_stall  = !w_cmd.in_ready;
    assign o_cfg_ready = w_cmd.in_ready;

    trfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    trfd_datapath #(
        .MAX_RECORDS (MAX_RECORDS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_cfg_write (i_cfg_valid && w_cmd.in_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== tb/sv/touch_event_checker.sv =====
// ----------------------------------------------------------------------------
// touch_event_checker
// Watches the byte, event and register channels of the touch report frame
// decoder. Every accepted byte runs through a local copy of the frame decoding
// rules, and the events it predicts are queued. Each accepted event word is
// compared field by field with the oldest queued event. The failure count and
// the number of events still outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module touch_event_checker #(
    parameter int unsigned MAX_RECORDS = 10,
    parameter int unsigned FRAME_BYTES = 60
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  trfd_pkg::t_in_word              i_in_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  trfd_pkg::t_out_word             i_out_word,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [trfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [trfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_fail_count
);
    import trfd_pkg::*;

    logic [3:0]  cfg_fingers;
    logic [3:0]  cfg_stride;
    logic [11:0] cfg_sens_w;
    logic [11:0] cfg_sens_h;
    logic [11:0] cfg_scr_x;
    logic [11:0] cfg_scr_y;

    logic [3:0]  byte_pos;
    logic [3:0]  rec_pos;
    logic        rec_live;
    logic [7:0]  x_hi;
    logic [7:0]  y_hi;
    logic        frame_has_finger;
    logic        pen_up;

    t_out_word   expected_events[$];
    int          fails = 0;

    function automatic t_out_word make_event(input logic [1:0] kind,
                                             input logic [11:0] px,
                                             input logic [11:0] py);
        t_out_word e;
        e.event_kind = kind;
        e.pos_x      = px;
        e.pos_y      = py;
        e.last       = 1'b0;
        return e;
    endfunction

    function automatic void decode_report_byte(input t_in_word w);
        int unsigned stride;
        int unsigned recs;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [11:0] div_w;
        logic [11:0] div_h;
        logic [23:0] sx;
        logic [23:0] sy;
        logic        rec_done;
        logic        frame_done;
        t_out_word   fresh [2];
        int          n_new;
        n_new = 0;
        if (w.frame_start) begin
            byte_pos         = '0;
            rec_pos          = '0;
            rec_live         = 1'b0;
            frame_has_finger = 1'b0;
        end
        stride = (cfg_stride < MIN_STRIDE) ? MIN_STRIDE : cfg_stride;
        recs   = (cfg_fingers == 0) ? 1 : cfg_fingers;
        if (recs > FRAME_BYTES / stride) recs = FRAME_BYTES / stride;
        if (recs > MAX_RECORDS) recs = MAX_RECORDS;
        if (recs < 1) recs = 1;

        case (byte_pos)
            4'd0: begin
                rec_live = (w.data_byte[1:0] != EMPTY_MASK);
                if (rec_live) frame_has_finger = 1'b1;
            end
            4'd1: x_hi = w.data_byte;
            4'd2: y_hi = w.data_byte;
            4'd3: begin
                if (rec_live) begin
                    raw_x = {x_hi, w.data_byte[7:4]};
                    raw_y = {y_hi, w.data_byte[3:0]};
                    div_w = (cfg_sens_w == 0) ? 12'd1 : cfg_sens_w;
                    div_h = (cfg_sens_h == 0) ? 12'd1 : cfg_sens_h;
                    sx = (24'(raw_x) * 24'(cfg_scr_y)) / 24'(div_w);
                    sy = (24'(raw_y) * 24'(cfg_scr_x)) / 24'(div_h);
                    if (sx <= 24'(cfg_scr_y) && sy <= 24'(cfg_scr_x)) begin
                        pen_up = 1'b0;
                        fresh[n_new] = make_event(KIND_FINGER, cfg_scr_x - sy[11:0],
                                                  sx[11:0]);
                        n_new++;
                    end
                end
            end
            default: ;
        endcase

        rec_done   = (int'(byte_pos) + 1 >= stride);
        frame_done = rec_done && (int'(rec_pos) + 1 >= recs);

        if (frame_done) begin
            if (frame_has_finger) begin
                fresh[n_new] = make_event(KIND_SYNC, '0, '0);
                n_new++;
            end else if (!pen_up) begin
                pen_up = 1'b1;
                fresh[n_new] = make_event(KIND_PENUP, '0, '0);
                n_new++;
            end
            byte_pos         = '0;
            rec_pos          = '0;
            rec_live         = 1'b0;
            frame_has_finger = 1'b0;
        end else if (rec_done) begin
            byte_pos = '0;
            rec_pos  = rec_pos + 4'd1;
        end else begin
            byte_pos = byte_pos + 4'd1;
        end

        if (n_new > 0) fresh[n_new-1].last = 1'b1;
        for (int k = 0; k < n_new; k++) expected_events.push_back(fresh[k]);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FINGER_COUNT:  cfg_fingers = data[3:0];
            CFG_RECORD_BYTES:  cfg_stride  = data[3:0];
            CFG_SENSOR_WIDTH:  cfg_sens_w  = data;
            CFG_SENSOR_HEIGHT: cfg_sens_h  = data;
            CFG_SCREEN_X_RES:  cfg_scr_x   = data;
            CFG_SCREEN_Y_RES:  cfg_scr_y   = data;
            default: ;
        endcase
    endfunction

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        fails++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            cfg_fingers      = 4'd5;
            cfg_stride       = 4'd6;
            cfg_sens_w       = 12'd800;
            cfg_sens_h       = 12'd480;
            cfg_scr_x        = 12'd800;
            cfg_scr_y        = 12'd480;
            byte_pos         = '0;
            rec_pos          = '0;
            rec_live         = 1'b0;
            x_hi             = '0;
            y_hi             = '0;
            frame_has_finger = 1'b0;
            pen_up           = 1'b0;
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_register(i_cfg_index, i_cfg_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    fails++;
                    $display("%0t: extra word, expected none, actual %0d/%0d/%0d/%0d",
                             $time, i_out_word.event_kind, i_out_word.pos_x,
                             i_out_word.pos_y, i_out_word.last);
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_word.event_kind !== want.event_kind)
                        report_field("event_kind", want.event_kind, i_out_word.event_kind);
                    if (i_out_word.pos_x !== want.pos_x)
                        report_field("pos_x", want.pos_x, i_out_word.pos_x);
                    if (i_out_word.pos_y !== want.pos_y)
                        report_field("pos_y", want.pos_y, i_out_word.pos_y);
                    if (i_out_word.last !== want.last)
                        report_field("last", want.last, i_out_word.last);
                end
            end
            if (i_in_valid && !i_in_stall) decode_report_byte(i_in_word);
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/sv/touch_report_frame_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// touch_report_frame_decoder_top_test
// Drives report byte streams into the frame decoder under a series of
// register settings: reset defaults, corner values and random ones. A short
// directed run covers full-scale and zero points, empty frames, pen-up and
// restart within a frame; random frames follow, mostly well formed with
// noise and cut-off frames mixed in. Both sides stall at random, and the
// event side holds off for long stretches twice. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module touch_report_frame_decoder_top_test;

    import trfd_pkg::*;

    localparam int unsigned MAX_RECORDS = 10;
    localparam int unsigned FRAME_BYTES = 60;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum {START_RANDOM, START_ALWAYS, START_NEVER} t_start_rule;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_word              in_word = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending;
    int                    fails;
    int unsigned           cycle_count = 0;

    t_reg_write            reg_writes[$];
    int                    items_left;
    bit                    send_calm = 1'b0;
    t_start_rule           start_rule = START_RANDOM;
    logic [3:0]            sh_fc = 4'd5;
    logic [3:0]            sh_rb = 4'd6;
    logic [11:0]           sh_sw = 12'd800;
    logic [11:0]           sh_sh = 12'd480;

    touch_report_frame_decoder_top #(
        .MAX_RECORDS (MAX_RECORDS),
        .FRAME_BYTES (FRAME_BYTES)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    touch_event_checker #(
        .MAX_RECORDS (MAX_RECORDS),
        .FRAME_BYTES (FRAME_BYTES)
    ) event_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fails)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("touch_report_frame_decoder_top verification failed");
            $finish;
        end
    end

    // event side: random stall per word, calm stretches, two long hold-offs
    initial begin : event_sink
        int wait_cycles;
        int words_taken;
        bit calm;
        words_taken = 0;
        calm = 1'b0;
        forever begin
            if (words_taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
            if (words_taken == 40 || words_taken == 120) wait_cycles = LONG_HOLD;
            else if (calm) wait_cycles = 0;
            else wait_cycles = $urandom_range(0, 6);
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            words_taken++;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        t_in_word w;
        gap = send_calm ? 0 : $urandom_range(0, 6);
        w.data_byte   = data;
        w.frame_start = start;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic put_byte(input logic [7:0] data, input logic start);
        if (items_left > 0) begin
            send_byte(data, start);
            items_left--;
        end
    endtask

    task automatic send_frame();
        int          stride;
        int          recs;
        int          shape;
        int          cut;
        int          b;
        int          dw;
        int          dh;
        bit          all_empty;
        logic        start;
        logic [7:0]  data;
        logic [11:0] rx;
        logic [11:0] ry;
        stride = (sh_rb < MIN_STRIDE) ? MIN_STRIDE : sh_rb;
        recs   = (sh_fc == 0) ? 1 : sh_fc;
        if (recs > FRAME_BYTES / stride) recs = FRAME_BYTES / stride;
        if (recs > MAX_RECORDS) recs = MAX_RECORDS;
        dw = (sh_sw == 0) ? 1 : sh_sw;
        dh = (sh_sh == 0) ? 1 : sh_sh;
        send_calm = ($urandom_range(0, 5) == 0);
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 8))
                put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            start_rule = START_ALWAYS;
            return;
        end
        cut = (shape == 1) ? $urandom_range(1, recs * stride - 1) : recs * stride;
        all_empty = ($urandom_range(0, 7) == 0);
        case (start_rule)
            START_ALWAYS: start = 1'b1;
            START_NEVER:  start = 1'b0;
            default:      start = ($urandom_range(0, 3) != 0);
        endcase
        for (int k = 0; k < cut; k++) begin
            b = k % stride;
            if (b == 0) begin
                data = 8'($urandom_range(0, 255));
                if (all_empty || $urandom_range(0, 3) == 0) data[1:0] = EMPTY_MASK;
                else data[1:0] = 2'($urandom_range(0, 2));
                rx = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 4095))
                                                 : 12'($urandom_range(0, dw));
                ry = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 4095))
                                                 : 12'($urandom_range(0, dh));
            end else if (b == 1) begin
                data = rx[11:4];
            end else if (b == 2) begin
                data = ry[11:4];
            end else if (b == 3) begin
                data = {rx[3:0], ry[3:0]};
            end else begin
                data = 8'($urandom_range(0, 255));
            end
            put_byte(data, (k == 0) ? start : 1'b0);
        end
        start_rule = (shape == 1) ? START_ALWAYS : START_RANDOM;
    endtask

    task automatic run_random(input int n);
        items_left = n;
        while (items_left > 0) send_frame();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input int fc, input int rb, input int sw,
                                  input int sh, input int sx, input int sy);
        t_reg_write w;
        wait_drained();
        w.idx = CFG_FINGER_COUNT;
        w.data = 12'($urandom_range(0, 4095));
        w.data[3:0] = 4'(fc);
        reg_writes.push_back(w);
        w.idx = CFG_RECORD_BYTES;
        w.data = 12'($urandom_range(0, 4095));
        w.data[3:0] = 4'(rb);
        reg_writes.push_back(w);
        w.idx = CFG_SENSOR_WIDTH;  w.data = 12'(sw); reg_writes.push_back(w);
        w.idx = CFG_SENSOR_HEIGHT; w.data = 12'(sh); reg_writes.push_back(w);
        w.idx = CFG_SCREEN_X_RES;  w.data = 12'(sx); reg_writes.push_back(w);
        w.idx = CFG_SCREEN_Y_RES;  w.data = 12'(sy); reg_writes.push_back(w);
        while (reg_writes.size() > 0) begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        sh_fc = 4'(fc);
        sh_rb = 4'(rb);
        sh_sw = 12'(sw);
        sh_sh = 12'(sh);
    endtask

    initial begin : stimulus
        t_reg_write spare;
        int fc;
        int rb;
        int sw;
        int sh;
        int sx;
        int sy;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, first frame without a start mark
        start_rule = START_NEVER;
        run_random(120);

        // full scale settings, one record of four bytes per frame
        apply_settings(1, 4, 4095, 4095, 4095, 4095);
        items_left = 22;
        send_calm = 1'b0;
        put_byte(8'h00, 1'b1); put_byte(8'hff, 1'b0);
        put_byte(8'hff, 1'b0); put_byte(8'hff, 1'b0);
        put_byte(8'h03, 1'b1); put_byte(8'h12, 1'b0);
        put_byte(8'h34, 1'b0); put_byte(8'h56, 1'b0);
        put_byte(8'hff, 1'b0); put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b1); put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
        // restart within a frame
        put_byte(8'h01, 1'b1); put_byte(8'h80, 1'b0);
        put_byte(8'h02, 1'b1); put_byte(8'h80, 1'b0);
        put_byte(8'h80, 1'b0); put_byte(8'h88, 1'b0);
        in_valid <= 1'b0;

        apply_settings(1, 4, 1, 1, 1, 1);
        start_rule = START_ALWAYS;
        run_random(60);

        // spare register slots must be ignored
        spare.idx = CFG_SPARE_LO; spare.data = 12'hfff; reg_writes.push_back(spare);
        spare.idx = CFG_SPARE_HI; spare.data = 12'h000; reg_writes.push_back(spare);
        apply_settings(0, 0, 0, 0, 0, 0);
        run_random(60);

        apply_settings(15, 15, 4095, 4095, 4095, 4095);
        run_random(80);

        apply_settings(10, 12, 4095, 1, 1, 4095);
        run_random(80);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            fc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
            rb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 12);
            sw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4095);
            sh = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4095);
            sx = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4095);
            sy = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4095);
            apply_settings(fc, rb, sw, sh, sx, sy);
            run_random(100);
        end

        wait_drained();
        if (fails == 0 && pending == 0) begin
            $display("touch_report_frame_decoder_top verification clean");
        end else begin
            $display("touch_report_frame_decoder_top verification failed");
        end
        $finish;
    end

endmodule
